/* rtl/core/escape_sequence_payload_decoder_defines.svh */
// assertion macros shared by the escape decoder modules
// expects clk_i and rst_ni in the scope of each use
`ifndef ESCAPE_SEQUENCE_PAYLOAD_DECODER_DEFINES_SVH
`define ESCAPE_SEQUENCE_PAYLOAD_DECODER_DEFINES_SVH

// property must hold at every clock edge out of reset
`define ESD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define ESD_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

/* rtl/core/esd_pkg.sv */
// types and constants of the escape sequence payload decoder
// no dependencies; used by esd_step, esd_rfifo and the top level
package esd_pkg;

  localparam int unsigned MAX_REPEAT_DEF = 65536;
  localparam int unsigned RUN_W          = 17;
  localparam int unsigned CHAR_W         = 8;
  localparam int unsigned QDEPTH         = 3;
  localparam int unsigned CNT_W          = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_RUN  = 2'd1,
    KIND_ERR  = 2'd2,
    KIND_END  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ERR_SHORT  = 2'd0,
    ERR_HEX    = 2'd1,
    ERR_SYNTAX = 2'd2,
    ERR_LIMIT  = 2'd3
  } err_e;

  typedef enum logic [2:0] {
    M_NORMAL  = 3'd0,
    M_ESC     = 3'd1,
    M_HEX1    = 3'd2,
    M_HEX2    = 3'd3,
    M_ZFIRST  = 3'd4,
    M_ZDIGITS = 3'd5,
    M_SKIP    = 3'd6
  } mode_e;

  typedef struct packed {
    kind_e              kind;
    logic [CHAR_W-1:0]  out_byte;
    logic [RUN_W-1:0]   run_length;
    err_e               error_code;
    logic               end_of_output;
  } res_t;

  // results of one input beat, cnt of them valid (0 to 2)
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

endpackage

/* rtl/core/esd_step.sv */
// per-character decode: mode and repeat count registers plus result logic
// depends on esd_pkg and the shared assertion macros
`include "escape_sequence_payload_decoder_defines.svh"

module esd_step #(
  parameter int unsigned MAX_REPEAT = esd_pkg::MAX_REPEAT_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic [esd_pkg::CHAR_W-1:0] in_char_i,
  input  logic                       string_end_i,
  output esd_pkg::push_t             push_o
);
  import esd_pkg::*;

  localparam logic [CHAR_W-1:0] CH_BSL  = 8'h5C;
  localparam logic [CHAR_W-1:0] CH_X    = 8'h78;
  localparam logic [CHAR_W-1:0] CH_Z    = 8'h7A;
  localparam logic [CHAR_W-1:0] CH_N    = 8'h6E;
  localparam logic [CHAR_W-1:0] CH_R    = 8'h72;
  localparam logic [CHAR_W-1:0] CH_T    = 8'h74;
  localparam logic [CHAR_W-1:0] CH_0    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9    = 8'h39;
  localparam logic [CHAR_W-1:0] BYTE_LF = 8'h0A;
  localparam logic [CHAR_W-1:0] BYTE_CR = 8'h0D;
  localparam logic [CHAR_W-1:0] BYTE_HT = 8'h09;
  localparam logic [63:0]       MAX_REP = 64'(MAX_REPEAT);

  // bit 4 set when the character is no hex digit
  function automatic logic [4:0] hex_val(logic [CHAR_W-1:0] c);
    logic [4:0] v;
    if (c >= 8'h30 && c <= 8'h39)      v = 5'(c - 8'h30);
    else if (c >= 8'h61 && c <= 8'h66) v = 5'(c - 8'h61 + 8'd10);
    else if (c >= 8'h41 && c <= 8'h46) v = 5'(c - 8'h41 + 8'd10);
    else                               v = 5'h10;
    return v;
  endfunction

  mode_e       mode_q, mode_d;
  logic [3:0]  nib_q, nib_d;
  logic        hbad_q, hbad_d;
  logic [63:0] val_q, val_d;
  logic        ovf_q, ovf_d;
  logic        oct_q, oct_d;
  logic        obad_q, obad_d;

  logic [CHAR_W-1:0] c;
  logic              fin;
  logic              is_dig;
  logic [3:0]        dig;
  logic [4:0]        hv;
  logic              starts_esc;
  logic [66:0]       oct_wide;
  logic [67:0]       dec_wide;
  logic [63:0]       val_upd;
  logic              ovf_upd, oct_upd, obad_upd;
  logic              cnt_done, cnt_syntax, cnt_limit;
  logic              in_z, skip;
  logic              fail;
  err_e              err;
  push_t             push;

  assign c          = in_char_i;
  assign fin        = string_end_i;
  assign is_dig     = (c >= CH_0) && (c <= CH_9);
  assign dig        = 4'(c - CH_0);
  assign hv         = hex_val(c);
  assign starts_esc = (c == CH_BSL) && !fin;
  assign oct_wide   = {val_q, 3'b000} + 67'(dig);
  assign dec_wide   = 68'({val_q, 3'b000}) + 68'({val_q, 1'b0}) + 68'(dig);
  assign in_z       = (mode_q == M_ZFIRST) || (mode_q == M_ZDIGITS);
  assign skip       = (mode_q == M_SKIP);

  // repeat count after this character
  always_comb begin
    val_upd  = val_q;
    ovf_upd  = ovf_q;
    oct_upd  = oct_q;
    obad_upd = obad_q;
    if (mode_q == M_ZFIRST && is_dig) begin
      oct_upd = (c == CH_0);
      val_upd = 64'(dig);
    end else if (mode_q == M_ZDIGITS && is_dig) begin
      if (oct_q) begin
        if (dig >= 4'd8) obad_upd = 1'b1;
        else if (!ovf_q) begin
          if (oct_wide[66:64] != 3'd0) ovf_upd = 1'b1;
          else                         val_upd = oct_wide[63:0];
        end
      end else if (!ovf_q) begin
        if (dec_wide[67:64] != 4'd0) ovf_upd = 1'b1;
        else                         val_upd = dec_wide[63:0];
      end
    end
  end

  assign cnt_done   = in_z && !(mode_q == M_ZFIRST && !is_dig) && (!is_dig || fin);
  assign cnt_syntax = obad_upd || ovf_upd;
  assign cnt_limit  = val_upd > MAX_REP;

  // error detection
  always_comb begin
    fail = 1'b0;
    err  = ERR_SHORT;
    unique case (mode_q)
      M_ESC: begin
        if (c == CH_X && fin) begin
          fail = 1'b1;
          err  = ERR_SHORT;
        end else if (c == CH_Z && fin) begin
          fail = 1'b1;
          err  = ERR_SYNTAX;
        end
      end
      M_HEX1: begin
        fail = fin;
        err  = ERR_SHORT;
      end
      M_HEX2: begin
        fail = hbad_q || hv[4];
        err  = ERR_HEX;
      end
      M_ZFIRST, M_ZDIGITS: begin
        if (mode_q == M_ZFIRST && !is_dig) begin
          fail = 1'b1;
          err  = ERR_SYNTAX;
        end else if (cnt_done && cnt_syntax) begin
          fail = 1'b1;
          err  = ERR_SYNTAX;
        end else if (cnt_done && cnt_limit) begin
          fail = 1'b1;
          err  = ERR_LIMIT;
        end
      end
      default: begin
        fail = 1'b0;
      end
    endcase
  end

  // next state
  always_comb begin
    mode_d = mode_q;
    nib_d  = nib_q;
    hbad_d = hbad_q;
    val_d  = val_q;
    ovf_d  = ovf_q;
    oct_d  = oct_q;
    obad_d = obad_q;
    unique case (mode_q)
      M_NORMAL: mode_d = starts_esc ? M_ESC : M_NORMAL;
      M_ESC: begin
        mode_d = M_NORMAL;
        if (c == CH_X) mode_d = M_HEX1;
        else if (c == CH_Z) begin
          val_d  = '0;
          ovf_d  = 1'b0;
          oct_d  = 1'b0;
          obad_d = 1'b0;
          mode_d = M_ZFIRST;
        end
      end
      M_HEX1: begin
        hbad_d = hv[4];
        nib_d  = hv[3:0];
        mode_d = M_HEX2;
      end
      M_HEX2: mode_d = M_NORMAL;
      M_ZFIRST, M_ZDIGITS: begin
        val_d  = val_upd;
        ovf_d  = ovf_upd;
        oct_d  = oct_upd;
        obad_d = obad_upd;
        if (is_dig)          mode_d = M_ZDIGITS;
        else if (starts_esc) mode_d = M_ESC;
        else                 mode_d = M_NORMAL;
      end
      default: mode_d = mode_q;
    endcase
    if (fail) mode_d = M_SKIP;
    if (fin) begin
      mode_d = M_NORMAL;
      nib_d  = '0;
      hbad_d = 1'b0;
      val_d  = '0;
      ovf_d  = 1'b0;
      oct_d  = 1'b0;
      obad_d = 1'b0;
    end
  end

  // results of this beat
  always_comb begin
    logic run_push;
    logic dat_push;
    res_t run_r;
    res_t dat_r;
    run_push = 1'b0;
    dat_push = 1'b0;
    run_r    = '0;
    dat_r    = '0;
    run_r.kind       = KIND_RUN;
    run_r.run_length = val_upd[RUN_W-1:0];
    dat_r.kind       = KIND_DATA;
    dat_r.out_byte   = c;
    unique case (mode_q)
      M_NORMAL: dat_push = !starts_esc;
      M_ESC: begin
        if (c == CH_N) begin
          dat_push       = 1'b1;
          dat_r.out_byte = BYTE_LF;
        end else if (c == CH_R) begin
          dat_push       = 1'b1;
          dat_r.out_byte = BYTE_CR;
        end else if (c == CH_T) begin
          dat_push       = 1'b1;
          dat_r.out_byte = BYTE_HT;
        end else begin
          dat_push = (c != CH_X) && (c != CH_Z);
        end
      end
      M_HEX2: begin
        dat_push       = !(hbad_q || hv[4]);
        dat_r.out_byte = {nib_q, hv[3:0]};
      end
      M_ZFIRST, M_ZDIGITS: begin
        if (cnt_done && !cnt_syntax && !cnt_limit) begin
          run_push = (val_upd != 64'd0);
          dat_push = !is_dig && !starts_esc;
        end
      end
      default: begin
        dat_push = 1'b0;
      end
    endcase

    push = '0;
    if (run_push && dat_push) begin
      push.cnt = 2'd2;
      push.r0  = run_r;
      push.r1  = dat_r;
    end else if (run_push) begin
      push.cnt = 2'd1;
      push.r0  = run_r;
    end else if (dat_push) begin
      push.cnt = 2'd1;
      push.r0  = dat_r;
    end

    if (fail) begin
      push                  = '0;
      push.cnt              = 2'd1;
      push.r0.kind          = KIND_ERR;
      push.r0.error_code    = err;
      push.r0.end_of_output = 1'b1;
    end else if (fin && !skip) begin
      if (push.cnt == 2'd2)      push.r1.end_of_output = 1'b1;
      else if (push.cnt == 2'd1) push.r0.end_of_output = 1'b1;
      else begin
        push.cnt              = 2'd1;
        push.r0.kind          = KIND_END;
        push.r0.end_of_output = 1'b1;
      end
    end
  end

  assign push_o = push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_NORMAL;
      nib_q  <= '0;
      hbad_q <= 1'b0;
      val_q  <= '0;
      ovf_q  <= 1'b0;
      oct_q  <= 1'b0;
      obad_q <= 1'b0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      nib_q  <= nib_d;
      hbad_q <= hbad_d;
      val_q  <= val_d;
      ovf_q  <= ovf_d;
      oct_q  <= oct_d;
      obad_q <= obad_d;
    end
  end

  // a pair is always a zero run followed by the byte that ended the count
  `ESD_ASSERT(a_pair_order, (push.cnt == 2'd2) |-> (push.r0.kind == KIND_RUN && push.r1.kind == KIND_DATA), "bad result pair")
  // an error stands alone and closes the string
  `ESD_ASSERT(a_err_alone, fail |-> (push.cnt == 2'd1 && push.r0.end_of_output), "error not final")
  // every string starts in normal mode
  `ESD_ASSERT(a_end_clears, (accept_i && fin) |=> (mode_q == M_NORMAL && !ovf_q && val_q == 64'd0), "state not cleared")
  `ESD_NEVER(a_no_skip_out, skip && push.cnt != 2'd0, "result while skipping")

endmodule

/* rtl/core/esd_rfifo.sv */
// three-entry result queue, up to two writes and one read per cycle
// depends on esd_pkg and the shared assertion macros
`include "escape_sequence_payload_decoder_defines.svh"

module esd_rfifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_en_i,
  input  esd_pkg::push_t push_i,
  input  logic           rd_i,
  output logic           nonempty_o,
  output logic           full2_o,
  output esd_pkg::res_t  head_o
);
  import esd_pkg::*;

  res_t             ent_q [QDEPTH];
  res_t             ent_d [QDEPTH];
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] cnt_pop;
  logic [CNT_W-1:0] wr_n;
  logic             pop;

  assign pop     = rd_i && (cnt_q != '0);
  assign cnt_pop = cnt_q - CNT_W'(pop);
  assign wr_n    = wr_en_i ? CNT_W'(push_i.cnt) : '0;
  assign cnt_d   = cnt_pop + wr_n;

  // room for two more beats counts the read of this cycle
  assign full2_o    = cnt_pop > CNT_W'(QDEPTH - 2);
  assign nonempty_o = cnt_q != '0;
  assign head_o     = ent_q[0];

  always_comb begin
    for (int i = 0; i < QDEPTH; i++) begin
      if (pop && i < QDEPTH - 1) ent_d[i] = ent_q[(i + 1) % QDEPTH];
      else                       ent_d[i] = ent_q[i];
      if (wr_n != '0 && CNT_W'(i) == cnt_pop)                   ent_d[i] = push_i.r0;
      if (wr_n == CNT_W'(2) && CNT_W'(i) == cnt_pop + CNT_W'(1)) ent_d[i] = push_i.r1;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QDEPTH; i++) ent_q[i] <= ent_d[i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else         cnt_q <= cnt_d;
  end

  `ESD_ASSERT(a_fill_bound, 1'b1 |-> (cnt_q <= CNT_W'(QDEPTH)), "queue over depth")
  `ESD_NEVER(a_no_overrun, (32'(cnt_pop) + 32'(wr_n)) > QDEPTH, "queue overrun")
  `ESD_ASSERT(a_cnt_track, 1'b1 |=> (cnt_q == $past(cnt_q) - CNT_W'($past(pop)) + $past(wr_n)), "count slip")

endmodule

/* rtl/core/escape_sequence_payload_decoder.sv */
// top level of the backslash escape decoder
// depends on esd_pkg, esd_step and esd_rfifo
//
// Input channel: one character of an escaped string per beat (in_char_i,
// string_end_i marks the last character). A beat is taken when in_valid_i
// is high and in_stall_o is low. Output channel: one result per beat
// (kind_o, out_byte_o, run_length_o, error_code_o, end_of_output_o), taken
// when out_valid_o is high and out_stall_i is low.
// Each character is decoded in the cycle it is taken and its results
// (none, one or two) are written to a registered three-entry result
// queue, from whose head they are offered.
// Throughput is one character per cycle while characters give at most one
// result each and the receiver does not stall; a character that gives two
// results (a zero run and the character that ended its count) is slowed
// by the single-result output port.
// in_stall_o is raised when the queue, after this cycle's read, has room
// for fewer than two results; a stalled receiver thus backs up into the
// input channel after at most three results. Reset empties the queue and
// returns the decoder to normal character mode.
module escape_sequence_payload_decoder #(
  parameter int unsigned MAX_REPEAT = esd_pkg::MAX_REPEAT_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [esd_pkg::CHAR_W-1:0] in_char_i,
  input  logic                       string_end_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [1:0]                 kind_o,
  output logic [esd_pkg::CHAR_W-1:0] out_byte_o,
  output logic [esd_pkg::RUN_W-1:0]  run_length_o,
  output logic [1:0]                 error_code_o,
  output logic                       end_of_output_o
);
  import esd_pkg::*;

  logic  accept;
  logic  full2;
  push_t push;
  res_t  head;

  assign in_stall_o = full2;
  assign accept     = in_valid_i && !full2;

  esd_step #(
    .MAX_REPEAT(MAX_REPEAT)
  ) u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .in_char_i   (in_char_i),
    .string_end_i(string_end_i),
    .push_o      (push)
  );

  esd_rfifo u_rfifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (accept),
    .push_i    (push),
    .rd_i      (!out_stall_i),
    .nonempty_o(out_valid_o),
    .full2_o   (full2),
    .head_o    (head)
  );

  assign kind_o          = head.kind;
  assign out_byte_o      = head.out_byte;
  assign run_length_o    = head.run_length;
  assign error_code_o    = head.error_code;
  assign end_of_output_o = head.end_of_output;

endmodule

/* dv/escape_sequence_payload_decoder_tb.sv */
`timescale 1ns / 100ps
// self-checking testbench for escape_sequence_payload_decoder: directed and random escaped
// strings, bursty sender, stalling receiver, per-character decode predictor
// depends on esd_pkg and the decoder rtl
module escape_sequence_payload_decoder_tb;
  import esd_pkg::*;

  localparam int unsigned ITEM_TARGET  = 1750;
  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned TAIL_CYCLES  = 20;
  localparam int unsigned PRINT_CAP    = 100;
  localparam logic [63:0] RUN_LIMIT    = 64'(MAX_REPEAT_DEF);
  localparam logic [63:0] U64_MAX      = '1;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_X      = "x";
  localparam logic [7:0] CH_Z      = "z";
  localparam logic [7:0] CH_N      = "n";
  localparam logic [7:0] CH_R      = "r";
  localparam logic [7:0] CH_T      = "t";
  localparam logic [7:0] CH_0      = "0";
  localparam logic [7:0] CH_9      = "9";

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_beat_t;

  logic             clk_i        = 1'b0;
  logic             rst_ni       = 1'b0;
  logic             in_valid_i   = 1'b0;
  logic             in_stall_o;
  logic [CHAR_W-1:0] in_char_i   = '0;
  logic             string_end_i = 1'b0;
  logic             out_valid_o;
  logic             out_stall_i  = 1'b0;
  logic [1:0]       kind_o;
  logic [CHAR_W-1:0] out_byte_o;
  logic [RUN_W-1:0] run_length_o;
  logic [1:0]       error_code_o;
  logic             end_of_output_o;

  escape_sequence_payload_decoder dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .in_char_i       (in_char_i),
    .string_end_i    (string_end_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .kind_o          (kind_o),
    .out_byte_o      (out_byte_o),
    .run_length_o    (run_length_o),
    .error_code_o    (error_code_o),
    .end_of_output_o (end_of_output_o)
  );

  char_beat_t  char_q[$];
  res_t        decoded_q[$];
  res_t        step_res[$];
  logic [7:0]  text[$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  // predictor state
  mode_e       dec_mode;
  logic [3:0]  hi_nibble;
  logic        hi_bad;
  logic [63:0] count_val;
  logic        count_ovf;
  logic        count_octal;
  logic        count_bad8;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    if (error_count < PRINT_CAP) $display("ERROR @%0d: %s", cycle_count, msg);
    error_count++;
  endtask

  task automatic add_res(input res_t r);
    step_res.insert(step_res.size(), r);
  endtask

  task automatic add_text(input logic [7:0] c);
    text.insert(text.size(), c);
  endtask

  function automatic res_t make_res(kind_e k, logic [7:0] b, logic [16:0] run, err_e e);
    res_t r;
    r.kind          = k;
    r.out_byte      = b;
    r.run_length    = run;
    r.error_code    = e;
    r.end_of_output = 1'b0;
    return r;
  endfunction

  // 16 flags a non-hex character
  function automatic logic [4:0] hex_value(logic [7:0] c);
    logic [7:0] t;
    t = 8'd16;
    if (c >= "0" && c <= "9") t = c - "0";
    else if (c >= "a" && c <= "f") t = c - "a" + 8'd10;
    else if (c >= "A" && c <= "F") t = c - "A" + 8'd10;
    return t[4:0];
  endfunction

  task automatic clear_decoder();
    dec_mode    = M_NORMAL;
    hi_nibble   = '0;
    hi_bad      = 1'b0;
    count_val   = '0;
    count_ovf   = 1'b0;
    count_octal = 1'b0;
    count_bad8  = 1'b0;
  endtask

  task automatic plain_char(input logic [7:0] c, input logic last);
    if (c == CH_BSLASH && !last) begin
      dec_mode = M_ESC;
    end else begin
      dec_mode = M_NORMAL;
      add_res(make_res(KIND_DATA, c, '0, ERR_SHORT));
    end
  endtask

  task automatic decode_char(input logic [7:0] c, input logic last);
    mode_e       m;
    logic        fail;
    err_e        ecode;
    logic        digit;
    logic [63:0] d;
    logic [4:0]  hv;
    res_t        tail;
    m     = dec_mode;
    fail  = 1'b0;
    ecode = ERR_SHORT;
    digit = (c >= CH_0 && c <= CH_9);
    d     = {56'd0, c - CH_0};
    step_res.delete();
    case (m)
      M_NORMAL: plain_char(c, last);
      M_ESC: begin
        dec_mode = M_NORMAL;
        if (c == CH_N) add_res(make_res(KIND_DATA, 8'h0A, '0, ERR_SHORT));
        else if (c == CH_R) add_res(make_res(KIND_DATA, 8'h0D, '0, ERR_SHORT));
        else if (c == CH_T) add_res(make_res(KIND_DATA, 8'h09, '0, ERR_SHORT));
        else if (c == CH_X) begin
          if (last) fail = 1'b1;
          else dec_mode = M_HEX1;
        end else if (c == CH_Z) begin
          count_val   = '0;
          count_ovf   = 1'b0;
          count_octal = 1'b0;
          count_bad8  = 1'b0;
          if (last) begin
            fail  = 1'b1;
            ecode = ERR_SYNTAX;
          end else begin
            dec_mode = M_ZFIRST;
          end
        end else begin
          add_res(make_res(KIND_DATA, c, '0, ERR_SHORT));
        end
      end
      M_HEX1: begin
        hv        = hex_value(c);
        hi_bad    = hv[4];
        hi_nibble = hv[3:0];
        if (last) fail = 1'b1;
        else dec_mode = M_HEX2;
      end
      M_HEX2: begin
        hv       = hex_value(c);
        dec_mode = M_NORMAL;
        if (hi_bad || hv[4]) begin
          fail  = 1'b1;
          ecode = ERR_HEX;
        end else begin
          add_res(make_res(KIND_DATA, {hi_nibble, hv[3:0]}, '0, ERR_SHORT));
        end
      end
      M_ZFIRST, M_ZDIGITS: begin
        if (digit) begin
          if (m == M_ZFIRST) begin
            count_octal = (c == CH_0);
            count_val   = d;
          end else if (count_octal) begin
            if (d >= 64'd8) count_bad8 = 1'b1;
            else if (!count_ovf) begin
              if (count_val > ((U64_MAX - d) >> 3)) count_ovf = 1'b1;
              else count_val = (count_val << 3) + d;
            end
          end else if (!count_ovf) begin
            if (count_val > (U64_MAX - d) / 64'd10) count_ovf = 1'b1;
            else count_val = count_val * 64'd10 + d;
          end
          dec_mode = M_ZDIGITS;
        end
        if (m == M_ZFIRST && !digit) begin
          fail  = 1'b1;
          ecode = ERR_SYNTAX;
        end else if (!digit || last) begin
          dec_mode = M_NORMAL;
          if (count_bad8 || count_ovf) begin
            fail  = 1'b1;
            ecode = ERR_SYNTAX;
          end else if (count_val > RUN_LIMIT) begin
            fail  = 1'b1;
            ecode = ERR_LIMIT;
          end else begin
            if (count_val != '0)
              add_res(make_res(KIND_RUN, 8'h00, count_val[16:0], ERR_SHORT));
            // the character that closed the count is decoded in the same beat
            if (!digit) plain_char(c, last);
          end
        end
      end
      default: m = M_SKIP;
    endcase
    if (fail) begin
      step_res.delete();
      tail = make_res(KIND_ERR, 8'h00, '0, ecode);
      tail.end_of_output = 1'b1;
      add_res(tail);
      dec_mode = M_SKIP;
    end
    if (last) begin
      if (!fail && m != M_SKIP) begin
        if (step_res.size() > 0) tail = step_res.pop_back();
        else tail = make_res(KIND_END, 8'h00, '0, ERR_SHORT);
        tail.end_of_output = 1'b1;
        add_res(tail);
      end
      clear_decoder();
    end
    foreach (step_res[i]) decoded_q.insert(decoded_q.size(), step_res[i]);
  endtask

  // ---------------- stimulus construction ----------------

  task automatic flush_text();
    char_beat_t b;
    foreach (text[i]) begin
      b.ch   = text[i];
      b.last = (i == text.size() - 1);
      char_q.insert(char_q.size(), b);
    end
    text.delete();
  endtask

  task automatic append_str(input string s);
    for (int i = 0; i < s.len(); i++) add_text(s[i]);
  endtask

  function automatic logic [7:0] pick_hex_char(input logic bad);
    logic [7:0] c;
    int unsigned v;
    if (bad) begin
      c = 8'($urandom_range(0, 255));
      while (hex_value(c) != 5'd16) c = 8'($urandom_range(0, 255));
    end else begin
      v = $urandom_range(0, 15);
      if (v < 10) c = CH_0 + 8'(v);
      else if ($urandom_range(0, 1) == 0) c = 8'(v - 10) + "a";
      else c = 8'(v - 10) + "A";
    end
    return c;
  endfunction

  function automatic string pick_count();
    logic [63:0] v;
    string s;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: s = $sformatf("%0d", $urandom_range(1, 300));
      4: s = $sformatf("%0d", $urandom_range(65530, 65540));
      5: s = $sformatf("0%0o", $urandom_range(0, 4095));
      6: s = $sformatf("0%0o%0d%0d", $urandom_range(0, 63), $urandom_range(8, 9),
                       $urandom_range(0, 9));
      7: begin
        // edges of the 64-bit count range in both radixes
        case ($urandom_range(0, 5))
          0: s = "18446744073709551615";
          1: s = "18446744073709551616";
          2: s = "99999999999999999999999";
          3: s = "01777777777777777777777";
          4: s = "02000000000000000000000";
          default: s = "0177777777777777777777777";
        endcase
      end
      8: begin
        v = {$urandom, $urandom};
        s = $sformatf("%0d", v);
      end
      default: s = $sformatf("%0d", $urandom_range(0, 9));
    endcase
    return s;
  endfunction

  task automatic build_random_string();
    int unsigned nseg;
    int unsigned pick;
    logic [7:0]  c;
    logic        stop;
    int unsigned bad_pos;
    if ($urandom_range(0, 19) == 0) begin
      repeat ($urandom_range(1, 8)) add_text(8'($urandom_range(0, 255)));
    end else begin
      nseg = $urandom_range(1, 5);
      stop = 1'b0;
      while (nseg > 0 && !stop) begin
        pick = $urandom_range(0, 99);
        nseg--;
        if (pick < 20) begin
          c = 8'($urandom_range(0, 255));
          add_text(c == CH_BSLASH ? 8'h41 : c);
        end else if (pick < 30) begin
          add_text(CH_BSLASH);
          case ($urandom_range(0, 2))
            0: add_text(CH_N);
            1: add_text(CH_R);
            default: add_text(CH_T);
          endcase
        end else if (pick < 45) begin
          bad_pos = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : 0;
          add_text(CH_BSLASH);
          add_text(CH_X);
          add_text(pick_hex_char(bad_pos == 1));
          add_text(pick_hex_char(bad_pos == 2));
        end else if (pick < 50) begin
          // hex escape cut off by the end of the string
          add_text(CH_BSLASH);
          add_text(CH_X);
          if ($urandom_range(0, 1) == 0) add_text(pick_hex_char(1'b0));
          stop = 1'b1;
        end else if (pick < 75) begin
          add_text(CH_BSLASH);
          add_text(CH_Z);
          append_str(pick_count());
          if ($urandom_range(0, 1) == 0) begin
            c = 8'($urandom_range(0, 255));
            add_text((c >= CH_0 && c <= CH_9) ? CH_BSLASH : c);
          end
        end else if (pick < 85) begin
          add_text(CH_BSLASH);
          add_text(8'($urandom_range(0, 255)));
        end else if (pick < 92) begin
          add_text(CH_BSLASH);
          add_text(CH_Z);
          if ($urandom_range(0, 2) == 0) stop = 1'b1;
          else add_text("q");
        end else begin
          add_text(8'($urandom_range(0, 255)));
        end
      end
      if (!stop && $urandom_range(0, 7) == 0) add_text(CH_BSLASH);
    end
    flush_text();
  endtask

  initial begin
    clear_decoder();
    // directed strings
    add_text(8'h00);
    add_text(8'hFF);
    flush_text();
    append_str("\\x");      flush_text();
    append_str("\\xA");     flush_text();
    append_str("\\xg1a");   flush_text();
    append_str("\\z");      flush_text();
    append_str("\\z0");     flush_text();
    append_str("\\z07\\n"); flush_text();
    append_str("\\");       flush_text();
    while (char_q.size() < ITEM_TARGET) build_random_string();

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (char_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // ---------------- sender: bursts with random gaps ----------------

  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;
  char_beat_t  next_beat;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      in_char_i    <= '0;
      string_end_i <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (char_q.size() > 0) begin
        next_beat = char_q.pop_front();
        in_valid_i   <= 1'b1;
        in_char_i    <= next_beat.ch;
        string_end_i <= next_beat.last;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---------------- receiver: stall styles that change over time ----------------

  int unsigned stall_style = 0;
  int unsigned stall_left  = 0;
  int unsigned hold_left   = 0;
  int unsigned stall_tick  = 0;
  logic        stall_on    = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      stall_tick++;
      if (stall_left == 0) begin
        stall_style = $urandom_range(0, 3);
        stall_left  = $urandom_range(50, 300);
      end else begin
        stall_left--;
      end
      case (stall_style)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 2) == 0);
        2: out_stall_i <= (stall_tick % 5 < 2);
        default: begin
          if (hold_left == 0) begin
            hold_left = $urandom_range(1, 16);
            stall_on  = ~stall_on;
          end else begin
            hold_left--;
          end
          out_stall_i <= stall_on;
        end
      endcase
    end
  end

  // ---------------- monitor and checker ----------------

  res_t want_res;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
        $display("timeout after %0d cycles", cycle_count);
        $display("simulation failed");
        $finish;
      end else begin
        if (in_valid_i && !in_stall_o) decode_char(in_char_i, string_end_i);
        if (out_valid_o && !out_stall_i) begin
          if (decoded_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result beat, kind %0d", kind_o));
          end else begin
            want_res = decoded_q.pop_front();
            if (kind_o !== want_res.kind)
              report_mismatch($sformatf("kind %0d, want %0d", kind_o, want_res.kind));
            if (out_byte_o !== want_res.out_byte)
              report_mismatch($sformatf("out_byte %02h, want %02h", out_byte_o,
                                        want_res.out_byte));
            if (run_length_o !== want_res.run_length)
              report_mismatch($sformatf("run_length %0d, want %0d", run_length_o,
                                        want_res.run_length));
            if (error_code_o !== want_res.error_code)
              report_mismatch($sformatf("error_code %0d, want %0d", error_code_o,
                                        want_res.error_code));
            if (end_of_output_o !== want_res.end_of_output)
              report_mismatch($sformatf("end_of_output %0d, want %0d", end_of_output_o,
                                        want_res.end_of_output));
          end
        end
      end
    end
  end

endmodule
